/* design/ffsa_pkg.sv */
package ffsa_pkg;

  localparam int unsigned DefMaxSegments = 128;
  localparam int unsigned DefOwnerBits   = 8;
  localparam logic [15:0] ResetTotalUnits = 16'd512;

  localparam logic        CmdAlloc   = 1'b0;
  localparam logic        CmdRelease = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoFit    = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;
  localparam logic [1:0] StatusFull     = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_SPLIT_SHIFT,
    OP_SPLIT_FIX,
    OP_MARK,
    OP_REL_FREE,
    OP_REL_RIGHT,
    OP_LEFT_READ,
    OP_REL_LEFT,
    OP_DROP_SHIFT,
    OP_DROP_END
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_end;
    logic fit_exact;
    logic table_full;
    logic size_zero;
    logic is_release;
    logic shift_done;
    logic right_free;
    logic left_free;
    logic drop_done;
  } dp_status_t;

endpackage

/* design/first_fit_segment_allocator.sv */
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    cmd, request_size, owner_id
// out      output     out_valid/out_stall  status, base_address, free_total
// cfg      input      cfg_we               cfg_wdata (total_units)
// One request at a time; a request scans the segment table entry by entry and
// moves table entries to open a slot for a split or close one after a merge.
// The segment table does one registered read and at most one write per cycle.
// Reset, or a write of total_units, loads one free segment covering all memory.
// A result holds on the output while out_stall is high.
module first_fit_segment_allocator #(
  parameter int unsigned MaxSegments = ffsa_pkg::DefMaxSegments,
  parameter int unsigned OwnerBits   = ffsa_pkg::DefOwnerBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [15:0] request_size_i,
  input  logic [7:0]  owner_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] base_address_o,
  output logic [15:0] free_total_o
);
  import ffsa_pkg::*;

  dp_cmd_t    dcmd;
  dp_status_t dsts;
  logic       accept;
  logic       fin;
  logic [1:0] fin_status;

  ffsa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sts_i        (dsts),
    .cmd_o        (dcmd),
    .accept_o     (accept),
    .fin_o        (fin),
    .fin_status_o (fin_status)
  );

  ffsa_dp #(
    .MaxSegments (MaxSegments),
    .OwnerBits   (OwnerBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .request_size_i (request_size_i),
    .owner_id_i     (owner_id_i),
    .cmd_o_i        (dcmd),
    .sts_o          (dsts),
    .fin_i          (fin),
    .fin_status_i   (fin_status),
    .status_o       (status_o),
    .base_address_o (base_address_o),
    .free_total_o   (free_total_o)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept while result pending");
  a_fin_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> out_valid_o) else $error("finish without result");
  a_err_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StatusOk) |-> base_address_o == 16'd0)
    else $error("error result with nonzero base");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) &&
    $stable(base_address_o) && $stable(free_total_o)))
    else $error("stalled result changed");
`endif

endmodule

/* design/ffsa_ctrl.sv */
module ffsa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  ffsa_pkg::dp_status_t  sts_i,
  output ffsa_pkg::dp_cmd_t     cmd_o,
  output logic                  accept_o,
  output logic                  fin_o,
  output logic [1:0]            fin_status_o
);
  import ffsa_pkg::*;

  localparam logic [3:0] StIdle      = 4'd0;
  localparam logic [3:0] StScan      = 4'd1;
  localparam logic [3:0] StSplitSh   = 4'd2;
  localparam logic [3:0] StSplitFix  = 4'd3;
  localparam logic [3:0] StMark      = 4'd4;
  localparam logic [3:0] StRelFree   = 4'd5;
  localparam logic [3:0] StRelRight  = 4'd6;
  localparam logic [3:0] StDropShR   = 4'd7;
  localparam logic [3:0] StOut       = 4'd8;
  localparam logic [3:0] StDecide    = 4'd9;
  localparam logic [3:0] StLeftRd    = 4'd10;
  localparam logic [3:0] StRelLeft   = 4'd11;
  localparam logic [3:0] StDropShL   = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign accept_o    = (state_q == StIdle) && in_valid_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    fin_o        = 1'b0;
    fin_status_o = StatusOk;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = StDecide;
        end
      end
      StDecide: begin
        if (!sts_i.is_release && sts_i.size_zero) begin
          fin_o = 1'b1;
          fin_status_o = StatusNoFit;
          state_d = StOut;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (sts_i.scan_hit) begin
          if (sts_i.is_release) begin
            state_d = StRelFree;
          end else if (sts_i.fit_exact) begin
            state_d = StMark;
          end else if (sts_i.table_full) begin
            fin_o = 1'b1;
            fin_status_o = StatusFull;
            state_d = StOut;
          end else begin
            state_d = StSplitSh;
          end
        end else if (sts_i.scan_end) begin
          fin_o = 1'b1;
          fin_status_o = sts_i.is_release ? StatusNotFound : StatusNoFit;
          state_d = StOut;
        end else begin
          cmd_o.op = OP_SCAN;
        end
      end
      StSplitSh: begin
        if (sts_i.shift_done) begin
          state_d = StSplitFix;
        end else begin
          cmd_o.op = OP_SPLIT_SHIFT;
        end
      end
      StSplitFix: begin
        cmd_o.op = OP_SPLIT_FIX;
        state_d  = StMark;
      end
      StMark: begin
        cmd_o.op = OP_MARK;
        fin_o    = 1'b1;
        state_d  = StOut;
      end
      StRelFree: begin
        cmd_o.op = OP_REL_FREE;
        state_d  = StRelRight;
      end
      StRelRight: begin
        cmd_o.op = OP_REL_RIGHT;
        state_d  = sts_i.right_free ? StDropShR : StLeftRd;
      end
      StDropShR: begin
        if (sts_i.drop_done) begin
          cmd_o.op = OP_DROP_END;
          state_d  = StLeftRd;
        end else begin
          cmd_o.op = OP_DROP_SHIFT;
        end
      end
      StLeftRd: begin
        cmd_o.op = OP_LEFT_READ;
        state_d  = StRelLeft;
      end
      StRelLeft: begin
        cmd_o.op = OP_REL_LEFT;
        if (sts_i.left_free) begin
          state_d = StDropShL;
        end else begin
          fin_o   = 1'b1;
          state_d = StOut;
        end
      end
      StDropShL: begin
        if (sts_i.drop_done) begin
          cmd_o.op = OP_DROP_END;
          fin_o    = 1'b1;
          state_d  = StOut;
        end else begin
          cmd_o.op = OP_DROP_SHIFT;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/ffsa_dp.sv */
module ffsa_dp #(
  parameter int unsigned MaxSegments = ffsa_pkg::DefMaxSegments,
  parameter int unsigned OwnerBits   = ffsa_pkg::DefOwnerBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 accept_i,
  input  logic                 cmd_i,
  input  logic [15:0]          request_size_i,
  input  logic [7:0]           owner_id_i,
  input  ffsa_pkg::dp_cmd_t    cmd_o_i,
  output ffsa_pkg::dp_status_t sts_o,
  input  logic                 fin_i,
  input  logic [1:0]           fin_status_i,
  output logic [1:0]           status_o,
  output logic [15:0]          base_address_o,
  output logic [15:0]          free_total_o
);
  import ffsa_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxSegments);

  typedef struct packed {
    logic [15:0]          start;
    logic [15:0]          len;
    logic                 used;
    logic [OwnerBits-1:0] owner;
  } seg_t;

  seg_t mem_q [MaxSegments];
  seg_t rd_q;

  logic [CntW-1:0]      count_q;
  logic [15:0]          free_q;
  logic [15:0]          total_q;
  logic                 init_q;
  logic [CntW-1:0]      ptr_q;
  logic                 step_q;
  logic                 hit_v_q;
  logic [CntW-1:0]      hit_q;
  seg_t                 seg_q;
  logic [CntW-1:0]      wp_q;
  logic [15:0]          rel_base_q;
  logic                 is_rel_q;
  logic [15:0]          size_q;
  logic [OwnerBits-1:0] owner_q;
  logic [1:0]           status_q;
  logic [15:0]          base_q;

  logic            we;
  logic [IdxW-1:0] wa;
  seg_t            wd;
  logic [IdxW-1:0] ra;
  logic            match;
  logic            right_free;
  logic            left_free;

  assign match = ptr_q < count_q &&
                 (is_rel_q ? (rd_q.used && rd_q.owner == owner_q)
                           : (!rd_q.used && rd_q.len >= size_q));
  assign right_free = (hit_q + CntW'(1) < count_q) && !rd_q.used;
  assign left_free  = (hit_q != '0) && !rd_q.used;

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rd_q;
    ra = ptr_q[IdxW-1:0];
    case (cmd_o_i.op)
      OP_SPLIT_SHIFT: begin
        ra = IdxW'(wp_q - CntW'(1));
        if (step_q) begin
          we = 1'b1;
          wa = wp_q[IdxW-1:0];
          wd = rd_q;
        end
      end
      OP_SPLIT_FIX: begin
        we = 1'b1;
        wa = IdxW'(hit_q + CntW'(1));
        wd = '0;
        wd.start = seg_q.start + size_q;
        wd.len   = seg_q.len - size_q;
      end
      OP_MARK: begin
        we = 1'b1;
        wa = hit_q[IdxW-1:0];
        wd.start = seg_q.start;
        wd.len   = size_q;
        wd.used  = 1'b1;
        wd.owner = owner_q;
      end
      OP_REL_FREE: begin
        we = 1'b1;
        wa = hit_q[IdxW-1:0];
        wd = '0;
        wd.start = seg_q.start;
        wd.len   = seg_q.len;
        ra = IdxW'(hit_q + CntW'(1));
      end
      OP_REL_RIGHT: begin
        if (right_free) begin
          we = 1'b1;
          wa = hit_q[IdxW-1:0];
          wd = '0;
          wd.start = seg_q.start;
          wd.len   = seg_q.len + rd_q.len;
        end
      end
      OP_LEFT_READ: begin
        ra = IdxW'(hit_q - CntW'(1));
      end
      OP_REL_LEFT: begin
        if (left_free) begin
          we = 1'b1;
          wa = IdxW'(hit_q - CntW'(1));
          wd = '0;
          wd.start = rd_q.start;
          wd.len   = rd_q.len + seg_q.len;
        end
      end
      OP_DROP_SHIFT: begin
        ra = IdxW'(wp_q + CntW'(1));
        if (step_q) begin
          we = 1'b1;
          wa = wp_q[IdxW-1:0];
          wd = rd_q;
        end
      end
      default: begin
      end
    endcase
    if (init_q) begin
      we = 1'b1;
      wa = '0;
      wd = '0;
      wd.len = total_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  assign sts_o.scan_hit   = hit_v_q;
  assign sts_o.scan_end   = ptr_q >= count_q;
  assign sts_o.fit_exact  = seg_q.len == size_q;
  assign sts_o.table_full = count_q >= MaxCnt;
  assign sts_o.size_zero  = size_q == '0;
  assign sts_o.is_release = is_rel_q;
  assign sts_o.shift_done = wp_q <= hit_q + CntW'(1);
  assign sts_o.right_free = right_free;
  assign sts_o.left_free  = left_free;
  assign sts_o.drop_done  = wp_q + CntW'(1) >= count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= CntW'(1);
      free_q     <= ResetTotalUnits;
      total_q    <= ResetTotalUnits;
      init_q     <= 1'b1;
      ptr_q      <= '0;
      step_q     <= 1'b0;
      hit_v_q    <= 1'b0;
      hit_q      <= '0;
      seg_q      <= '0;
      wp_q       <= '0;
      rel_base_q <= '0;
    end else begin
      init_q <= 1'b0;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
        free_q  <= cfg_wdata_i;
        count_q <= CntW'(1);
        init_q  <= 1'b1;
      end else begin
        case (cmd_o_i.op)
          OP_LOAD: begin
            ptr_q   <= '0;
            hit_v_q <= 1'b0;
            step_q  <= 1'b0;
          end
          OP_SCAN: begin
            if (!step_q) begin
              step_q <= 1'b1;
            end else begin
              step_q <= 1'b0;
              if (match) begin
                hit_v_q <= 1'b1;
                hit_q   <= ptr_q;
                seg_q   <= rd_q;
                wp_q    <= count_q;
              end else begin
                ptr_q <= ptr_q + CntW'(1);
              end
            end
          end
          OP_SPLIT_SHIFT: begin
            if (!step_q) begin
              step_q <= 1'b1;
            end else begin
              step_q <= 1'b0;
              wp_q   <= wp_q - CntW'(1);
            end
          end
          OP_SPLIT_FIX: begin
            count_q <= count_q + CntW'(1);
          end
          OP_MARK: begin
            free_q <= free_q - size_q;
          end
          OP_REL_FREE: begin
            free_q     <= free_q + seg_q.len;
            rel_base_q <= seg_q.start;
          end
          OP_REL_RIGHT: begin
            if (right_free) begin
              seg_q.len <= seg_q.len + rd_q.len;
              wp_q      <= hit_q + CntW'(1);
              step_q    <= 1'b0;
            end
          end
          OP_REL_LEFT: begin
            if (left_free) begin
              wp_q   <= hit_q;
              step_q <= 1'b0;
            end
          end
          OP_DROP_SHIFT: begin
            if (!step_q) begin
              step_q <= 1'b1;
            end else begin
              step_q <= 1'b0;
              wp_q   <= wp_q + CntW'(1);
            end
          end
          OP_DROP_END: begin
            count_q <= count_q - CntW'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      is_rel_q <= cmd_i;
      size_q   <= request_size_i;
      owner_q  <= OwnerBits'(owner_id_i);
    end
    if (fin_i) begin
      status_q <= fin_status_i;
      if (fin_status_i != StatusOk) begin
        base_q <= 16'd0;
      end else begin
        base_q <= is_rel_q ? rel_base_q : seg_q.start;
      end
    end
  end

  assign status_o       = status_q;
  assign base_address_o = base_q;
  assign free_total_o   = free_q;

endmodule
